// File: rtl/chi_pkg.sv
// Package for the chained hash index table: sizes, codes and the word types
// shared by the controller, the datapath, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps

package chi_pkg;

   localparam int MAX_ROWS        = 4096;
   localparam int MAX_PIECES      = 16;
   localparam int MAX_BUCKET_BITS = 10;

   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int HEAD_W     = ROW_W + 1;
   localparam int HEAD_DEPTH = MAX_PIECES * (2 ** MAX_BUCKET_BITS);
   localparam int HEAD_AW    = $clog2(HEAD_DEPTH);
   localparam int PCNT_W     = $clog2(MAX_PIECES + 1);
   localparam int BB_W       = $clog2(MAX_BUCKET_BITS + 1);
   localparam int STEP_W     = $clog2(MAX_ROWS + 1);
   localparam int LEN_W      = 13;
   localparam int LEN_LIMIT  = (MAX_ROWS < 8191) ? MAX_ROWS : 8191;
   localparam int CSR_W      = 13;
   localparam int CSR_AW     = 2;

   localparam logic [HEAD_W-1:0] NIL_ROW = '1;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_COUNT  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_DESTROYED = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_BUCKET_BITS  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_PIECE_COUNT  = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_ROW_CAPACITY = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [11:0] row_index;
      logic [31:0] hash_value;
      logic [3:0]  piece_index;
      logic [9:0]  bucket_index;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [LEN_W-1:0] chain_length;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic head_rd_ins;
      logic head_rd_cnt;
      logic sweep_wr;
      logic set_valid;
      logic kill_valid;
      logic set_invalid;
      logic set_destroyed;
      logic ins_wr;
      logic walk_step;
      logic next_piece;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       table_valid;
      logic       row_over;
      logic       walk_more;
      logic       last_piece;
      logic       sweep_last;
   } ctrl_status_type;

endpackage

// File: rtl/chained_hash_index_table.sv
// Top level of the chained hash index table: joins the controller and the
// datapath. Depends on chi_pkg, chi_ctrl and chi_datapath.
`timescale 1ns / 1ps

// The block handles one request word at a time and returns one response word
// for each. An insert goes through decode with the read of the bucket head
// memory, the write of both the row link and the new head, and the load of the
// response register, which waits while a stalled response still holds the
// output. A count walks each piece's chain in turn: the walk follows one link
// per cycle through the registered read port of the row link memory, and at
// the end of each chain but the last reads the next piece's head. A clear
// writes nil into every entry of the bucket head memory, one entry per cycle,
// 16384 entries at the default sizes; until the first clear, and after an
// insert whose row is out of range, the table reports invalid. Commands for an
// invalid table go from decode straight to the response load. The next request
// is taken in the cycle after the response register is loaded, even while that
// response still waits in the output register.
module chained_hash_index_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  chi_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output chi_pkg::rsp_type            rsp_data,
   input  logic                        csr_we,
   input  logic [chi_pkg::CSR_AW-1:0]  csr_index,
   input  logic [chi_pkg::CSR_W-1:0]   csr_wdata
);
   import chi_pkg::*;

   ctrl_cmd_type    ctrl;
   ctrl_status_type stat;

   chi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   chi_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctrl      (ctrl),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/chi_datapath.sv
// Datapath of the chained hash index table: configuration registers, the
// bucket head and row link memories, the chain walk counters and the result
// register. Depends on chi_pkg and is steered by chi_ctrl.
`timescale 1ns / 1ps

module chi_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  chi_pkg::req_type            req_data,
   input  logic                        csr_we,
   input  logic [chi_pkg::CSR_AW-1:0]  csr_index,
   input  logic [chi_pkg::CSR_W-1:0]   csr_wdata,
   input  chi_pkg::ctrl_cmd_type       ctrl,
   output chi_pkg::ctrl_status_type    stat,
   output chi_pkg::rsp_type            rsp_data
);
   import chi_pkg::*;

   logic [3:0]  bucket_bits_ff;
   logic [4:0]  piece_count_ff;
   logic [12:0] row_cap_ff;
   logic        table_valid_ff, table_valid_in;

   req_type              req_ff;
   logic [1:0]           status_ff, status_in;
   logic [LEN_W-1:0]     total_ff, total_in;
   logic [STEP_W-1:0]    steps_ff, steps_in;
   logic [PCNT_W-1:0]    piece_ff, piece_in;
   logic                 from_head_ff, from_head_in;
   logic [HEAD_AW-1:0]   sweep_addr_ff, sweep_addr_in;
   logic [HEAD_W-1:0]    head_q_ff;
   logic [HEAD_W-1:0]    link_q_ff;
   rsp_type              rsp_ff;

   logic [HEAD_W-1:0] head_mem [HEAD_DEPTH];
   logic [HEAD_W-1:0] link_mem [MAX_ROWS];

   logic [BB_W-1:0]            bits_eff;
   logic [MAX_BUCKET_BITS-1:0] mask;
   logic [PCNT_W-1:0]          pieces_eff;
   logic [PCNT_W-1:0]          ins_piece;
   logic [PCNT_W-1:0]          piece_nx;
   logic [MAX_BUCKET_BITS-1:0] ins_bucket;
   logic [MAX_BUCKET_BITS-1:0] cnt_bucket;
   logic [HEAD_AW-1:0]         slot;
   logic [HEAD_W-1:0]          cur;

   logic                head_we, head_re, link_we, link_re;
   logic [HEAD_AW-1:0]  head_waddr, head_raddr;
   logic [HEAD_W-1:0]   head_wdata;
   logic [ROW_W-1:0]    link_waddr, link_raddr;

   always_comb begin
      if (bucket_bits_ff == 4'd0) begin
         bits_eff = BB_W'(1);
      end else if (32'(bucket_bits_ff) > 32'(MAX_BUCKET_BITS)) begin
         bits_eff = BB_W'(MAX_BUCKET_BITS);
      end else begin
         bits_eff = BB_W'(bucket_bits_ff);
      end
      for (int i = 0; i < MAX_BUCKET_BITS; i++) begin
         mask[i] = (32'(i) < 32'(bits_eff));
      end
      if (piece_count_ff == 5'd0) begin
         pieces_eff = PCNT_W'(1);
      end else if (32'(piece_count_ff) > 32'(MAX_PIECES)) begin
         pieces_eff = PCNT_W'(MAX_PIECES);
      end else begin
         pieces_eff = PCNT_W'(piece_count_ff);
      end
      if (32'(req_ff.piece_index) >= 32'(pieces_eff)) begin
         ins_piece = pieces_eff - 1'b1;
      end else begin
         ins_piece = PCNT_W'(req_ff.piece_index);
      end
   end

   assign ins_bucket = req_ff.hash_value[MAX_BUCKET_BITS-1:0] & mask;
   assign cnt_bucket = MAX_BUCKET_BITS'(req_ff.bucket_index) & mask;
   assign slot       = HEAD_AW'({ins_piece, ins_bucket});
   assign piece_nx   = piece_ff + 1'b1;
   assign cur        = from_head_ff ? head_q_ff : link_q_ff;

   assign stat.cmd         = req_ff.cmd;
   assign stat.table_valid = table_valid_ff;
   assign stat.row_over    = (32'(req_ff.row_index) >= 32'(row_cap_ff)) ||
                             (32'(req_ff.row_index) >= 32'(MAX_ROWS));
   assign stat.walk_more   = (32'(cur) < 32'(MAX_ROWS)) && (32'(steps_ff) < 32'(MAX_ROWS));
   assign stat.last_piece  = (piece_ff == pieces_eff - 1'b1);
   assign stat.sweep_last  = (32'(sweep_addr_ff) == 32'(HEAD_DEPTH - 1));

   assign head_we    = ctrl.sweep_wr | ctrl.ins_wr;
   assign head_waddr = ctrl.sweep_wr ? sweep_addr_ff : slot;
   assign head_wdata = ctrl.sweep_wr ? NIL_ROW : HEAD_W'(req_ff.row_index);
   assign head_re    = ctrl.head_rd_ins | ctrl.head_rd_cnt | ctrl.next_piece;
   always_comb begin
      if (ctrl.head_rd_ins) begin
         head_raddr = slot;
      end else if (ctrl.next_piece) begin
         head_raddr = HEAD_AW'({piece_nx, cnt_bucket});
      end else begin
         head_raddr = HEAD_AW'({piece_ff, cnt_bucket});
      end
   end
   assign link_we    = ctrl.ins_wr;
   assign link_waddr = ROW_W'(req_ff.row_index);
   assign link_re    = ctrl.walk_step;
   assign link_raddr = cur[ROW_W-1:0];

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      if (head_re) begin
         head_q_ff <= head_mem[head_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= head_q_ff;
      end
      if (link_re) begin
         link_q_ff <= link_mem[link_raddr];
      end
   end

   always_comb begin
      table_valid_in = table_valid_ff;
      if (ctrl.set_valid) begin
         table_valid_in = 1'b1;
      end else if (ctrl.kill_valid) begin
         table_valid_in = 1'b0;
      end
      status_in = status_ff;
      if (ctrl.load_req) begin
         status_in = ST_OK;
      end else if (ctrl.set_invalid) begin
         status_in = ST_INVALID;
      end else if (ctrl.set_destroyed) begin
         status_in = ST_DESTROYED;
      end
      total_in     = total_ff;
      steps_in     = steps_ff;
      piece_in     = piece_ff;
      from_head_in = from_head_ff;
      if (ctrl.load_req) begin
         total_in = '0;
         steps_in = '0;
         piece_in = '0;
      end else if (ctrl.head_rd_cnt) begin
         from_head_in = 1'b1;
      end else if (ctrl.walk_step) begin
         if (32'(total_ff) < 32'(LEN_LIMIT)) begin
            total_in = total_ff + 1'b1;
         end
         steps_in     = steps_ff + 1'b1;
         from_head_in = 1'b0;
      end else if (ctrl.next_piece) begin
         piece_in     = piece_nx;
         steps_in     = '0;
         from_head_in = 1'b1;
      end
      sweep_addr_in = sweep_addr_ff;
      if (ctrl.load_req) begin
         sweep_addr_in = '0;
      end else if (ctrl.sweep_wr) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_bits_ff <= 4'd10;
         piece_count_ff <= 5'd1;
         row_cap_ff     <= 13'd4096;
         table_valid_ff <= 1'b0;
      end else begin
         table_valid_ff <= table_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_BUCKET_BITS:  bucket_bits_ff <= csr_wdata[3:0];
               CSR_PIECE_COUNT:  piece_count_ff <= csr_wdata[4:0];
               CSR_ROW_CAPACITY: row_cap_ff     <= csr_wdata[12:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         req_ff <= req_data;
      end
      status_ff     <= status_in;
      total_ff      <= total_in;
      steps_ff      <= steps_in;
      piece_ff      <= piece_in;
      from_head_ff  <= from_head_in;
      sweep_addr_ff <= sweep_addr_in;
      if (ctrl.load_rsp) begin
         rsp_ff.status       <= status_ff;
         rsp_ff.chain_length <= total_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/chi_ctrl.sv
// Controller of the chained hash index table: the state machine that takes
// request words, sequences the datapath and hands over response words.
// Depends on chi_pkg and drives chi_datapath.
`timescale 1ns / 1ps

module chi_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  chi_pkg::ctrl_status_type   stat,
   output chi_pkg::ctrl_cmd_type      ctrl
);
   import chi_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_CLEAR  = 3'd2;
   localparam logic [2:0] S_INS_WR = 3'd3;
   localparam logic [2:0] S_WALK   = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctrl         = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.cmd)
               CMD_CLEAR: begin
                  state_in = S_CLEAR;
               end
               CMD_INSERT: begin
                  if (!stat.table_valid) begin
                     ctrl.set_invalid = 1'b1;
                     state_in         = S_DONE;
                  end else if (stat.row_over) begin
                     ctrl.kill_valid    = 1'b1;
                     ctrl.set_destroyed = 1'b1;
                     state_in           = S_DONE;
                  end else begin
                     ctrl.head_rd_ins = 1'b1;
                     state_in         = S_INS_WR;
                  end
               end
               CMD_COUNT: begin
                  if (!stat.table_valid) begin
                     ctrl.set_invalid = 1'b1;
                     state_in         = S_DONE;
                  end else begin
                     ctrl.head_rd_cnt = 1'b1;
                     state_in         = S_WALK;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_CLEAR: begin
            ctrl.sweep_wr = 1'b1;
            if (stat.sweep_last) begin
               ctrl.set_valid = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_INS_WR: begin
            ctrl.ins_wr = 1'b1;
            state_in    = S_DONE;
         end
         S_WALK: begin
            if (stat.walk_more) begin
               ctrl.walk_step = 1'b1;
            end else if (!stat.last_piece) begin
               ctrl.next_piece = 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ctrl.load_rsp = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/chi_checker.sv
// Port-level checker for the chained hash index table, bound to the top
// level. Depends on chi_pkg and chained_hash_index_table.
`timescale 1ns / 1ps

module chi_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  chi_pkg::rsp_type  rsp_data
);
   import chi_pkg::*;

   // An accepted word keeps the block busy for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted in back-to-back cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response word changed or dropped");

   a_len_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.chain_length == '0))
      else $error("chain length reported with a failing status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_INVALID ||
                     rsp_data.status == ST_DESTROYED))
      else $error("undefined status code");

   a_len_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.chain_length) <= 32'(LEN_LIMIT)))
      else $error("chain length beyond its limit");

endmodule

bind chained_hash_index_table chi_checker u_chi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
